[rtl/core/tmq_pkg.sv]
// tmq_pkg: shared constants and request/result types for the tagged message queue.
// No dependencies.
package tmq_pkg;

    localparam int ENTRIES   = 16;
    localparam int MAX_BYTES = 64;

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_BYTES + 1);
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int DEPTH  = ENTRIES * (2 ** IDX_W);

    localparam logic [1:0] KIND_ENQ      = 2'd0;
    localparam logic [1:0] KIND_DEQ      = 2'd1;
    localparam logic [1:0] KIND_DEQ_RANK = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NO_MATCH = 2'd2;
    localparam logic [1:0] STAT_TRUNC    = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rank;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_rank;
        logic [6:0] out_length;
        logic [7:0] out_byte;
        logic       out_byte_valid;
        logic       last_result;
        logic [4:0] entry_count;
    } rsp_t;

endpackage

[rtl/core/tagged_message_queue_core.sv]
// tagged_message_queue_core: top level, front request queue feeding the execution back end.
// Depends on tmq_pkg, tmq_front, tmq_back.
//
//  channel   ports                       handshake
//  request   start, busy, item           taken when start && !busy
//  result    result_strobe, result       one strobe per result, no stall
//
// Enqueue item: one result, in the cycle after it leaves the front queue
// (registered in the front queue, then in the result register, with the back end idle).
// Dequeue: a start step, for a rank match a search of up to held-count order-list entries,
// a removal step, then one result per byte at one per cycle (one result if empty).
// busy rises when the two-entry front queue is full.
// Reset clears control state; message contents are undefined until written.
module tagged_message_queue_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tmq_pkg::req_t item,
    output logic          busy,
    output logic          result_strobe,
    output tmq_pkg::rsp_t result
);

    logic          cmd_valid;
    logic          cmd_pop;
    tmq_pkg::req_t cmd;

    tmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tmq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (result.entry_count <= 5'(tmq_pkg::ENTRIES)))
        else $error("entry count beyond capacity");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.status != tmq_pkg::STAT_OK) |-> result.last_result)
        else $error("error status on non-final result");

    a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.out_byte_valid) |-> (result.out_length != 7'd0))
        else $error("content byte from empty message");

endmodule

[rtl/core/tmq_ram.sv]
// tmq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/tmq_front.sv]
// tmq_front: accepts requests into a two-entry queue, drops unused kinds.
// Depends on tmq_pkg.
module tmq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tmq_pkg::req_t item,
    output logic          busy,
    output logic          cmd_valid,
    output tmq_pkg::req_t cmd,
    input  logic          cmd_pop
);

    tmq_pkg::req_t buf_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push;

    assign busy      = (count_reg == 2'd2);
    assign push      = start && !busy && (item.kind != tmq_pkg::KIND_NONE);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (cmd_pop && cmd_valid);
        count_next  = count_reg + 2'(push) - 2'(cmd_pop && cmd_valid);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/tmq_back.sv]
// tmq_back: executes enqueue and dequeue requests, holds slot tables and order list.
// Depends on tmq_pkg and tmq_ram.
module tmq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  tmq_pkg::req_t cmd,
    output logic          cmd_pop,
    output logic          result_strobe,
    output tmq_pkg::rsp_t result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DEQ    = 2'd2;
    localparam logic [1:0] ST_STREAM = 2'd3;

    localparam logic [1:0] FM_IDLE = 2'd0;
    localparam logic [1:0] FM_FILL = 2'd1;
    localparam logic [1:0] FM_DISC = 2'd2;

    localparam int SW = tmq_pkg::SLOT_W;
    localparam int CW = tmq_pkg::CNT_W;
    localparam int IW = tmq_pkg::IDX_W;
    localparam int LW = tmq_pkg::LEN_W;
    localparam int AW = tmq_pkg::ADDR_W;
    localparam int N  = tmq_pkg::ENTRIES;

    logic [1:0]    state_reg, state_next;
    logic [1:0]    fmode_reg, fmode_next;
    logic [SW-1:0] fslot_reg, fslot_next;
    logic [LW-1:0] flen_reg, flen_next;
    logic          fcut_reg, fcut_next;
    logic [CW-1:0] held_reg, held_next;
    logic [N-1:0]  used_reg, used_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [7:0]    key_reg, key_next;
    logic [SW-1:0] cslot_reg, cslot_next;
    logic [LW-1:0] clen_reg, clen_next;
    logic [7:0]    crank_reg, crank_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          strobe_reg, strobe_next;
    tmq_pkg::rsp_t result_reg, result_next;

    logic [SW-1:0] order_reg [N];
    logic [7:0]    rank_reg [N];
    logic [LW-1:0] length_reg [N];

    logic          rank_we, len_we, app_we, compact_en;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] look_slot;
    logic [LW-1:0] look_len;

    tmq_ram #(.WIDTH(8), .DEPTH(tmq_pkg::DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        free_slot = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    assign look_slot = order_reg[pos_reg];
    assign look_len  = length_reg[look_slot];
    assign cmd_pop   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        fmode_next  = fmode_reg;
        fslot_next  = fslot_reg;
        flen_next   = flen_reg;
        fcut_next   = fcut_reg;
        held_next   = held_reg;
        used_next   = used_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        cslot_next  = cslot_reg;
        clen_next   = clen_reg;
        crank_next  = crank_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        result_next = '0;
        rank_we     = 1'b0;
        len_we      = 1'b0;
        app_we      = 1'b0;
        compact_en  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = {fslot_reg, flen_reg[IW-1:0]};
        ram_raddr   = {cslot_reg, IW'(idx_reg + 1'b1)};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind) inside
                        tmq_pkg::KIND_ENQ:
                        begin
                            if (fmode_next == FM_IDLE)
                            begin
                                if (held_reg == CW'(N))
                                begin
                                    fmode_next = FM_DISC;
                                end
                                else
                                begin
                                    fmode_next = FM_FILL;
                                    fslot_next = free_slot;
                                    flen_next  = '0;
                                    fcut_next  = 1'b0;
                                    rank_we    = 1'b1;
                                end
                            end
                            result_next.status = tmq_pkg::STAT_OK;
                            if (fmode_next == FM_DISC)
                            begin
                                result_next.status = tmq_pkg::STAT_FULL;
                            end
                            else if (cmd.byte_valid)
                            begin
                                if (flen_next < LW'(tmq_pkg::MAX_BYTES))
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = {fslot_next, flen_next[IW-1:0]};
                                    flen_next = flen_next + 1'b1;
                                end
                                else
                                begin
                                    fcut_next          = 1'b1;
                                    result_next.status = tmq_pkg::STAT_TRUNC;
                                end
                            end
                            if (cmd.last_byte)
                            begin
                                if (fmode_next == FM_FILL)
                                begin
                                    len_we               = 1'b1;
                                    app_we               = 1'b1;
                                    used_next[fslot_next] = 1'b1;
                                    held_next            = held_reg + 1'b1;
                                    if (fcut_next)
                                    begin
                                        result_next.status = tmq_pkg::STAT_TRUNC;
                                    end
                                end
                                fmode_next = FM_IDLE;
                                fcut_next  = 1'b0;
                            end
                            result_next.last_result = 1'b1;
                            result_next.entry_count = 5'(held_next);
                            strobe_next             = 1'b1;
                        end
                        tmq_pkg::KIND_DEQ, tmq_pkg::KIND_DEQ_RANK:
                        begin
                            pos_next = '0;
                            key_next = cmd.rank;
                            if (held_reg == '0)
                            begin
                                result_next.status      = tmq_pkg::STAT_NO_MATCH;
                                result_next.last_result = 1'b1;
                                result_next.entry_count = 5'(held_reg);
                                strobe_next             = 1'b1;
                            end
                            else if (cmd.kind == tmq_pkg::KIND_DEQ)
                            begin
                                state_next = ST_DEQ;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (rank_reg[look_slot] == key_reg)
                begin
                    state_next = ST_DEQ;
                end
                else if (CW'(pos_reg) + 1'b1 == held_reg)
                begin
                    result_next.status      = tmq_pkg::STAT_NO_MATCH;
                    result_next.last_result = 1'b1;
                    result_next.entry_count = 5'(held_reg);
                    strobe_next             = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_DEQ:
            begin
                compact_en           = 1'b1;
                held_next            = held_reg - 1'b1;
                used_next[look_slot] = 1'b0;
                cslot_next           = look_slot;
                clen_next            = look_len;
                crank_next           = rank_reg[look_slot];
                idx_next             = '0;
                ram_raddr            = {look_slot, {IW{1'b0}}};
                if (look_len == '0)
                begin
                    result_next.status      = tmq_pkg::STAT_OK;
                    result_next.out_rank    = rank_reg[look_slot];
                    result_next.last_result = 1'b1;
                    result_next.entry_count = 5'(held_next);
                    strobe_next             = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                result_next.status         = tmq_pkg::STAT_OK;
                result_next.out_rank       = crank_reg;
                result_next.out_length     = 7'(clen_reg);
                result_next.out_byte       = ram_rdata;
                result_next.out_byte_valid = 1'b1;
                result_next.entry_count    = 5'(held_reg);
                strobe_next                = 1'b1;
                idx_next                   = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == clen_reg)
                begin
                    result_next.last_result = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_reg[fslot_next] <= cmd.rank;
        end
        if (len_we)
        begin
            length_reg[fslot_next] <= flen_next;
        end
        if (app_we)
        begin
            order_reg[held_reg[SW-1:0]] <= fslot_next;
        end
        if (compact_en)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                if (SW'(i) >= pos_reg)
                begin
                    order_reg[i] <= order_reg[i + 1];
                end
            end
        end
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        cslot_reg  <= cslot_next;
        clen_reg   <= clen_next;
        crank_reg  <= crank_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fmode_reg  <= FM_IDLE;
            fslot_reg  <= '0;
            flen_reg   <= '0;
            fcut_reg   <= 1'b0;
            held_reg   <= '0;
            used_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fmode_reg  <= fmode_next;
            fslot_reg  <= fslot_next;
            flen_reg   <= flen_next;
            fcut_reg   <= fcut_next;
            held_reg   <= held_next;
            used_reg   <= used_next;
            strobe_reg <= strobe_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule
